// ===== rtl/sdt_pkg.sv =====
// sdt_pkg: shared types and constants for the descriptor handle slot table
// holds op codes, beat payload structs, controller state, command/status bundles
// no dependencies
`default_nettype none

package sdt_pkg;

	// default table geometry
	localparam int SLOTS_DEF      = 16;
	localparam int ENTRY_BITS_DEF = 64;

	// fixed field widths
	localparam int HANDLE_W = 32;
	localparam int DATA_W   = 64;

	typedef enum logic [1:0] {
		OP_PREPARE = 2'd0,
		OP_RESOLVE = 2'd1,
		OP_CANCEL  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	// request beat
	typedef struct packed {
		op_t                 op;
		logic [HANDLE_W-1:0] handle;
		logic [DATA_W-1:0]   entry_data;
	} in_item_t;

	// response beat
	typedef struct packed {
		logic [HANDLE_W-1:0] new_handle;
		logic                found;
		logic [DATA_W-1:0]   entry_out;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
		logic finish;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/sdt_if.sv =====
// sdt_if: valid/ready channel carrying one payload struct per beat
// payload type is a parameter; used with sdt_pkg::in_item_t and out_item_t
`default_nettype none

interface sdt_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sdt_ctrl.sv =====
// sdt_ctrl: controller state machine for the slot table
// sequences accept, slot scan, commit and response hand-off; uses sdt_pkg
`default_nettype none

module sdt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sdt_pkg::status_t st,
	output sdt_pkg::cmd_t        cmd
);
	import sdt_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (st.hit || st.last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.commit = st.hit;
				cmd.finish = st.hit || st.last;
			end
			ST_DONE: begin
				cmd.load_out = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// accepted request always starts a scan
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SCAN))
		else $error("accepted request did not enter scan");

	// a blocked response holds the controller
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !st.out_free) |=> (state_q == ST_DONE))
		else $error("response dropped while output busy");

	// handing off the response returns to idle
	a_done_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && st.out_free) |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle");

endmodule

`default_nettype wire

// ===== rtl/sdt_dp.sv =====
// sdt_dp: slot table datapath: slot memories, valid bits, id counter, scan
// pipeline, match logic and response register; commands from sdt_ctrl, uses sdt_pkg
`default_nettype none

module sdt_dp #(
	parameter int SLOTS      = sdt_pkg::SLOTS_DEF,
	parameter int ENTRY_BITS = sdt_pkg::ENTRY_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sdt_pkg::cmd_t    cmd,
	output sdt_pkg::status_t      st,
	input  wire sdt_pkg::in_item_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sdt_pkg::out_item_t    out_data
);
	import sdt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// slot storage
	logic [HANDLE_W-1:0]   handle_mem [SLOTS];
	logic [HANDLE_W-1:0]   cons_mem   [SLOTS];
	logic [ENTRY_BITS-1:0] entry_mem  [SLOTS];
	logic [SLOTS-1:0]      vld_q;

	// request registers
	op_t                 op_q;
	logic [HANDLE_W-1:0] id_q;
	logic [DATA_W-1:0]   data_q;

	// scan pipeline
	logic [IDX_W-1:0]      rd_addr_q;
	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  vld_s1;
	logic [HANDLE_W-1:0]   handle_s1;
	logic [HANDLE_W-1:0]   cons_s1;
	logic [ENTRY_BITS-1:0] entry_s1;

	logic [HANDLE_W-1:0] next_q;
	out_item_t           res_q;
	out_item_t           out_q;
	logic                out_valid_q;

	logic [HANDLE_W-1:0] cur_h, cur_c;
	logic                match;
	logic [HANDLE_W-1:0] new_id, next_d;
	logic                mem_we;
	logic [HANDLE_W-1:0] wr_handle, wr_cons;
	out_item_t           res_d;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= in_data.op;
			id_q   <= in_data.handle;
			data_q <= in_data.entry_data;
		end
	end

	// scan address and read-valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else if (cmd.start) begin
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan;
			if (cmd.scan) begin
				rd_addr_q <= (rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + 1'b1;
			end
		end
	end

	// slot memories, registered read
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			handle_s1 <= handle_mem[rd_addr_q];
			cons_s1   <= cons_mem[rd_addr_q];
			entry_s1  <= entry_mem[rd_addr_q];
			vld_s1    <= vld_q[rd_addr_q];
			idx_s1    <= rd_addr_q;
		end
		if (mem_we) begin
			handle_mem[idx_s1] <= wr_handle;
			cons_mem[idx_s1]   <= wr_cons;
		end
		if (cmd.commit && op_q == OP_PREPARE) begin
			entry_mem[idx_s1] <= data_q[ENTRY_BITS-1:0];
		end
	end

	// valid bits: unwritten slots read as free with a zero mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[idx_s1] <= 1'b1;
		end
	end

	// effective slot contents
	assign cur_h = vld_s1 ? handle_s1 : '0;
	assign cur_c = vld_s1 ? cons_s1 : '0;

	// id counter step, skipping zero on wrap
	always_comb begin
		if (next_q == '0) begin
			new_id = HANDLE_W'(1);
			next_d = HANDLE_W'(2);
		end else begin
			new_id = next_q;
			next_d = next_q + 1'b1;
		end
	end

	// per-op match condition
	always_comb begin
		case (op_q)
			OP_PREPARE: match = (cur_h == '0) || (cur_h == cur_c);
			OP_RESOLVE: match = (id_q != '0) && (cur_h == id_q);
			OP_CANCEL:  match = (cur_h == id_q);
			OP_RELEASE: match = (cur_h == id_q);
			default:    match = 1'b0;
		endcase
	end

	assign st.hit      = rd_valid_s1 && match;
	assign st.last     = rd_valid_s1 && (idx_s1 == LAST_IDX);
	assign st.out_free = !out_valid_q || out_ready;

	// slot write data
	assign mem_we = cmd.commit && (op_q != OP_RESOLVE);
	always_comb begin
		wr_handle = cur_h;
		wr_cons   = cur_c;
		case (op_q)
			OP_PREPARE: begin
				wr_handle = new_id;
				// a reclaimed slot gets its mark cleared, a free one keeps it
				wr_cons   = (cur_h == '0) ? cur_c : '0;
			end
			OP_CANCEL: begin
				wr_handle = '0;
			end
			OP_RELEASE: begin
				wr_cons = id_q;
			end
			default: begin
				wr_handle = cur_h;
			end
		endcase
	end

	// response value
	always_comb begin
		res_d = '0;
		if (cmd.commit) begin
			if (op_q == OP_PREPARE) begin
				res_d.new_handle = new_id;
			end
			if (op_q == OP_RESOLVE) begin
				res_d.found     = 1'b1;
				res_d.entry_out = DATA_W'(entry_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) res_q <= res_d;
		if (cmd.load_out) out_q <= res_q;
	end

	// id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= HANDLE_W'(1);
		end else if (cmd.commit && op_q == OP_PREPARE) begin
			next_q <= next_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a commit always refers to a slot read in the previous cycle
	a_commit_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> rd_valid_s1)
		else $error("commit without slot data");

	// prepare never hands out id zero
	a_prep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_PREPARE) |=> (res_q.new_handle != '0))
		else $error("prepare issued a zero id");

	// valid bits only ever get set
	a_vld_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(vld_q) >= $past($countones(vld_q))))
		else $error("slot valid bit cleared");

endmodule

`default_nettype wire

// ===== rtl/descriptor_handle_slot_table_unit.sv =====
// descriptor_handle_slot_table_unit: top level of the descriptor handle slot table
// joins sdt_ctrl and sdt_dp; channels are sdt_if instances, types from sdt_pkg
//
//   channel  dir  payload              beats
//   in_ch    in   op, handle, entry    one request per beat
//   out_ch   out  new_handle, found,   one response per request
//                 entry_out
//
// each request scans the slots from slot 0 one per cycle and stops at the
// first match or the last slot; its steps are accept, scan, then hand-off.
// the scan length is set by the single read port of the slot memories.
// reset clears valid bits, the id counter (to 1) and all handshake state.
// a stalled response is held in the output register; the next request is
// accepted while it waits.
`default_nettype none

module descriptor_handle_slot_table_unit #(
	parameter int SLOTS      = sdt_pkg::SLOTS_DEF,
	parameter int ENTRY_BITS = sdt_pkg::ENTRY_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sdt_if.sink       in_ch,
	sdt_if.source     out_ch
);
	import sdt_pkg::*;

	cmd_t    cmd;
	status_t st;

	// controller
	sdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	sdt_dp #(
		.SLOTS      (SLOTS),
		.ENTRY_BITS (ENTRY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_ch.data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data)
	);

endmodule

`default_nettype wire

// ===== tb/descriptor_handle_slot_table_unit_test.sv =====
// descriptor_handle_slot_table_unit_test: self-checking bench for the slot table top level
// directed and random prepare/resolve/cancel/release beats checked against a table model
// depends on sdt_pkg, sdt_if and descriptor_handle_slot_table_unit
`timescale 1ns / 1ps

module descriptor_handle_slot_table_unit_test;
	import sdt_pkg::*;

	localparam int SLOTS      = SLOTS_DEF;
	localparam int ENTRY_BITS = ENTRY_BITS_DEF;
	localparam logic [DATA_W-1:0] ENTRY_MASK = {DATA_W{1'b1}} >> (DATA_W - ENTRY_BITS);
	localparam int RANDOM_BEATS = 1900;

	logic clk;
	logic arst_n;

	sdt_if #(.payload_t(in_item_t))  in_ch ();
	sdt_if #(.payload_t(out_item_t)) out_ch ();

	descriptor_handle_slot_table_unit #(
		.SLOTS      (SLOTS),
		.ENTRY_BITS (ENTRY_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// table model state
	logic [HANDLE_W-1:0] slot_ids [SLOTS];
	logic [DATA_W-1:0]   slot_desc [SLOTS];
	logic [HANDLE_W-1:0] slot_marks [SLOTS];
	logic [HANDLE_W-1:0] id_counter;

	out_item_t pending_rsp [$];
	int        errors;

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int find_slot(logic [HANDLE_W-1:0] id);
		find_slot = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_ids[i] == id) begin
				find_slot = i;
				break;
			end
		end
	endfunction

	// apply one request to the model and return the response it should produce
	function automatic out_item_t table_apply(in_item_t req);
		out_item_t rsp;
		int        hit;
		rsp = '0;
		case (req.op)
			OP_PREPARE: begin
				for (int i = 0; i < SLOTS; i++) begin
					// consumed slots are reclaimed as the scan passes them
					if (slot_ids[i] != '0 && slot_marks[i] == slot_ids[i]) begin
						slot_marks[i] = '0;
						slot_ids[i]   = '0;
					end
					if (slot_ids[i] == '0) begin
						rsp.new_handle = id_counter;
						id_counter     = id_counter + 1;
						// id zero is skipped on wrap
						if (rsp.new_handle == '0) begin
							rsp.new_handle = id_counter;
							id_counter     = id_counter + 1;
						end
						slot_desc[i] = req.entry_data & ENTRY_MASK;
						slot_ids[i]  = rsp.new_handle;
						break;
					end
				end
			end
			OP_RESOLVE: begin
				if (req.handle != '0) begin
					hit = find_slot(req.handle);
					if (hit >= 0) begin
						rsp.found     = 1'b1;
						rsp.entry_out = slot_desc[hit] & ENTRY_MASK;
					end
				end
			end
			OP_CANCEL: begin
				hit = find_slot(req.handle);
				if (hit >= 0)
					slot_ids[hit] = '0;
			end
			default: begin
				hit = find_slot(req.handle);
				if (hit >= 0)
					slot_marks[hit] = req.handle;
			end
		endcase
		return rsp;
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// send one request beat; called at a falling edge, returns at a falling edge
	task automatic send_beat(op_t op, logic [HANDLE_W-1:0] handle,
			logic [DATA_W-1:0] data, int gap);
		in_item_t req;
		req.op         = op;
		req.handle     = handle;
		req.entry_data = data;
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data  = req;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_rsp.push_back(table_apply(req));
		@(negedge clk);
	endtask

	task automatic wait_all_responses();
		in_ch.valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	// response checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response new_handle=%h found=%b entry_out=%h",
					$time, out_ch.data.new_handle, out_ch.data.found,
					out_ch.data.entry_out);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (out_ch.data.new_handle !== want.new_handle) begin
					$display("%0t: new_handle expected %h actual %h",
						$time, want.new_handle, out_ch.data.new_handle);
					errors++;
				end
				if (out_ch.data.found !== want.found) begin
					$display("%0t: found expected %b actual %b",
						$time, want.found, out_ch.data.found);
					errors++;
				end
				if (out_ch.data.entry_out !== want.entry_out) begin
					$display("%0t: entry_out expected %h actual %h",
						$time, want.entry_out, out_ch.data.entry_out);
					errors++;
				end
			end
		end
	end

	// response side back-pressure, with occasional long open stretches
	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < 10) begin
				out_ch.ready = 1'b1;
				repeat ($urandom_range(100, 300)) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_ch.ready = 1'b0;
				repeat ($urandom_range(0, 99) < 85 ? $urandom_range(1, 3)
						: $urandom_range(10, 40)) @(negedge clk);
			end
		end
	end

	// id zero and unknown ids on an empty table
	task automatic test_empty_table();
		send_beat(OP_RESOLVE, '0, '0, 0);
		send_beat(OP_RELEASE, '0, {DATA_W{1'b1}}, 1);
		send_beat(OP_CANCEL, '0, '0, 0);
		send_beat(OP_RESOLVE, {HANDLE_W{1'b1}}, '0, 0);
	endtask

	// fill every slot with extreme descriptors, then one prepare too many
	task automatic test_fill_and_full();
		logic [DATA_W-1:0] data;
		for (int k = 0; k < SLOTS; k++) begin
			case (k % 4)
				0:       data = {DATA_W{1'b1}};
				1:       data = '0;
				2:       data = {DATA_W/2{2'b10}};
				default: data = {DATA_W/2{2'b01}};
			endcase
			send_beat(OP_PREPARE, {HANDLE_W{1'b1}}, data, k % 3);
		end
		send_beat(OP_PREPARE, '0, 64'h0123_4567_89ab_cdef, 0);
		send_beat(OP_RESOLVE, 32'd1, '0, 0);
		send_beat(OP_RELEASE, '0, '0, 0);
		send_beat(OP_CANCEL, '0, '0, 0);
	endtask

	// consumed marks, cancel of a released slot, reclaim on the prepare scan
	task automatic test_release_cancel();
		send_beat(OP_RELEASE, 32'd5, '0, 0);
		send_beat(OP_RELEASE, 32'd3, '0, 2);
		send_beat(OP_CANCEL, 32'd3, '0, 0);
		send_beat(OP_PREPARE, '0, 64'h8000_0000_0000_0001, 0);
		send_beat(OP_PREPARE, '0, 64'h7fff_ffff_ffff_fffe, 0);
		send_beat(OP_PREPARE, '0, '0, 0);
		send_beat(OP_RESOLVE, 32'd18, '0, 0);
		send_beat(OP_RESOLVE, 32'd5, '0, 0);
	endtask

	// handles mostly taken from live slots so that hits dominate
	function automatic logic [HANDLE_W-1:0] pick_handle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return slot_ids[$urandom_range(0, SLOTS - 1)];
		else if (r < 75)
			return '0;
		else if (r < 85)
			return $urandom;
		else
			return id_counter - $urandom_range(1, 40);
	endfunction

	task automatic test_random_traffic();
		int unsigned       r;
		op_t               op;
		logic [DATA_W-1:0] data;
		int                gap;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				op = OP_PREPARE;
			else if (r < 60)
				op = OP_RESOLVE;
			else if (r < 75)
				op = OP_CANCEL;
			else
				op = OP_RELEASE;
			data = {$urandom, $urandom};
			// back-to-back stretches with no sender gaps
			gap = ((n / 150) % 4 == 3) ? 0 : pick_gap();
			if (n == RANDOM_BEATS / 2)
				wait_all_responses();
			send_beat(op, pick_handle(), data, gap);
		end
	endtask

	initial begin
		errors       = 0;
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_ids[i]   = '0;
			slot_desc[i]  = '0;
			slot_marks[i] = '0;
		end
		id_counter = 32'd1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_table();
		test_fill_and_full();
		test_release_cancel();
		test_random_traffic();

		wait_all_responses();
		repeat (SLOTS + 8) @(negedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("** descriptor_handle_slot_table_unit: PASSED **");
		else
			$display("** descriptor_handle_slot_table_unit: FAILED **");
		$finish;
	end

	// hang guard
	initial begin
		#10_000_000;
		$display("** descriptor_handle_slot_table_unit: FAILED **");
		$finish;
	end

endmodule

// ===== descriptor_handle_slot_table_unit.f =====
rtl/sdt_pkg.sv
rtl/sdt_if.sv
rtl/sdt_ctrl.sv
rtl/sdt_dp.sv
rtl/descriptor_handle_slot_table_unit.sv
tb/descriptor_handle_slot_table_unit_test.sv
